/* sv/sts_pkg.sv */
// ----------------------------------------------------------------------------
// sts_pkg: shared types, constants and arithmetic helpers
// Sizes of the tableau, word layouts and the saturating Q16.16 helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

  localparam int MAX_ROWS   = 8;
  localparam int MAX_COLS   = 16;
  localparam int FRAC_BITS  = 16;
  localparam int STRIDE     = MAX_COLS + 1;
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int JCOL_W     = $clog2(STRIDE);
  localparam int WADDR_W    = $clog2(MAX_ROWS * STRIDE);
  localparam int CADDR_W    = ROW_W + COL_W;
  localparam int ACC_W      = DATA_W + FRAC_BITS + ROW_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int IT_W       = 8;
  localparam int NREG_W     = 4;
  localparam int NCOL_W     = $clog2(MAX_COLS + 1);

  localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] Q_ONE   = DATA_W'(1) << FRAC_BITS;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_COST  = 2'd0;
  localparam kind_t KIND_COEF  = 2'd1;
  localparam kind_t KIND_RHS   = 2'd2;
  localparam kind_t KIND_SOLVE = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OPTIMAL   = 2'd0;
  localparam status_t STATUS_UNBOUNDED = 2'd1;
  localparam status_t STATUS_LIMIT     = 2'd2;

  localparam logic RK_OBJECTIVE = 1'b0;
  localparam logic RK_BASIC     = 1'b1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_NUM_CONSTRAINTS = 2'd0;
  localparam cfg_idx_t CFG_NUM_VARIABLES   = 2'd1;
  localparam cfg_idx_t CFG_MINIMIZE        = 2'd2;
  localparam cfg_idx_t CFG_ITERATION_LIMIT = 2'd3;

  typedef struct packed {
    kind_t                    kind;
    logic [2:0]               row;
    logic [3:0]               col;
    logic signed [DATA_W-1:0] value;
    logic                     relation_ge;
  } in_word_t;

  typedef struct packed {
    logic                     result_kind;
    logic [3:0]               var_index;
    logic signed [DATA_W-1:0] result_value;
    status_t                  status;
    logic                     last;
  } out_word_t;

  // Saturate a wide signed value to the 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat64(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > PROD_W'(INT_MAX)) r = INT_MAX;
    else if (v < PROD_W'(INT_MIN)) r = INT_MIN;
    else r = v[DATA_W-1:0];
    return r;
  endfunction

  // Negate with saturation of the most negative value.
  function automatic logic signed [DATA_W-1:0] neg32(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v == INT_MIN) r = INT_MAX;
    else r = -v;
    return r;
  endfunction

  function automatic logic [WADDR_W-1:0] widx(input logic [ROW_W-1:0] r,
                                              input logic [JCOL_W-1:0] c);
    return WADDR_W'(r) * WADDR_W'(STRIDE) + WADDR_W'(c);
  endfunction

endpackage

`default_nettype wire

/* sv/sts_in_if.sv */
// ----------------------------------------------------------------------------
// sts_in_if: load and solve word channel
// Valid/ready channel carrying one input word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sts_in_if;
  logic             valid;
  logic             ready;
  sts_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/sts_out_if.sv */
// ----------------------------------------------------------------------------
// sts_out_if: result word channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sts_out_if;
  logic               valid;
  logic               ready;
  sts_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/simplex_tableau_solver_top.sv */
// ----------------------------------------------------------------------------
// simplex_tableau_solver_top: fixed-point tableau simplex solver
// Loads a small linear program word by word and solves it on command.
// ----------------------------------------------------------------------------
// Load words (cost, coefficient, right-hand side) are taken while idle.
// While a solve runs the input is not ready: the set-up pass visits each
// tableau entry (rows in use times 17), every reduced-cost pass reads,
// multiplies and accumulates each row for each used column, the ratio
// test reads each row and cross-multiplies where needed, and each pivot
// runs every pivot-row entry through the serial divider and then reads,
// multiplies and writes back each entry of every other row. All of it
// runs through one multiplier, one divider and the single read port of
// the working tableau memory. Results follow as one objective word and
// then one word per constraint row; each is held until taken.
`default_nettype none

module simplex_tableau_solver_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [sts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [sts_pkg::CFG_DATA_W-1:0]       cfg_data,
  sts_in_if.sink                                    item,
  sts_out_if.source                                 result
);

  typedef enum logic [4:0] {
    IDLE, SU_RD, SU_WR, RC_CHK, RC_RD, RC_MUL, RC_ACC, RC_FIN,
    EN_SCAN, EN_DEC, RT_RDA, RT_RDB, RT_CHK, RT_M1, RT_M2, RT_CMP, RT_END,
    PD_RD, PD_GO, PD_WAIT, RU_ROW, RU_F, RU_RDP, RU_RDI, RU_MUL, RU_WR,
    BASIS, OB_RD, OB_MUL, OB_ACC, RP_RD, OUT_WAIT
  } state_t;

  localparam int DW = sts_pkg::DATA_W;

  // Configuration registers.
  logic [sts_pkg::NREG_W-1:0] num_constraints;
  logic [sts_pkg::NREG_W-1:0] num_variables;
  logic                       minimize;
  logic [sts_pkg::IT_W-1:0]   iteration_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_constraints <= sts_pkg::NREG_W'(1);
      num_variables   <= sts_pkg::NREG_W'(1);
      minimize        <= 1'b0;
      iteration_limit <= sts_pkg::IT_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        sts_pkg::CFG_NUM_CONSTRAINTS: num_constraints <= cfg_data[sts_pkg::NREG_W-1:0];
        sts_pkg::CFG_NUM_VARIABLES:   num_variables   <= cfg_data[sts_pkg::NREG_W-1:0];
        sts_pkg::CFG_MINIMIZE:        minimize        <= cfg_data[0];
        sts_pkg::CFG_ITERATION_LIMIT: iteration_limit <= cfg_data[sts_pkg::IT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: rows clamped to 1..MAX_ROWS, variables to the columns left.
  logic [sts_pkg::NCOL_W-1:0] nr, nv, nv_lim, ncols;
  logic [sts_pkg::ROW_W-1:0]  nr_m1;
  logic [sts_pkg::NCOL_W-1:0] ncols_m1;

  always_comb begin
    if (num_constraints == '0) nr = sts_pkg::NCOL_W'(1);
    else if (num_constraints > sts_pkg::NREG_W'(sts_pkg::MAX_ROWS))
      nr = sts_pkg::NCOL_W'(sts_pkg::MAX_ROWS);
    else nr = sts_pkg::NCOL_W'(num_constraints);
    nv_lim = sts_pkg::NCOL_W'(sts_pkg::MAX_COLS) - nr;
    if (num_variables == '0) nv = sts_pkg::NCOL_W'(1);
    else if (sts_pkg::NCOL_W'(num_variables) > nv_lim) nv = nv_lim;
    else nv = sts_pkg::NCOL_W'(num_variables);
    ncols    = nv + nr;
    ncols_m1 = ncols - 1'b1;
    nr_m1    = sts_pkg::ROW_W'(nr - 1'b1);
  end

  // Loaded problem: costs, right-hand sides and relations in flip-flops,
  // coefficients in a memory.
  logic signed [DW-1:0] cost_row [sts_pkg::MAX_COLS];
  logic signed [DW-1:0] rhs_row  [sts_pkg::MAX_ROWS];
  logic                 row_ge   [sts_pkg::MAX_ROWS];
  logic signed [DW-1:0] coef_mem [2**sts_pkg::CADDR_W];
  logic signed [DW-1:0] coef_rdata;

  // Solver state.
  logic signed [DW-1:0]       w_mem [sts_pkg::MAX_ROWS * sts_pkg::STRIDE];
  logic signed [DW-1:0]       w_rdata;
  logic signed [DW-1:0]       basis_cost   [sts_pkg::MAX_ROWS];
  logic [sts_pkg::COL_W-1:0]  basis_column [sts_pkg::MAX_ROWS];
  logic signed [DW-1:0]       reduced_cost [sts_pkg::MAX_COLS];
  logic [sts_pkg::IT_W-1:0]   pivot_count;

  state_t                        state;
  logic [sts_pkg::ROW_W-1:0]     i, p;
  logic [sts_pkg::JCOL_W-1:0]    j;
  logic [sts_pkg::COL_W-1:0]     e;
  logic                          e_valid, p_valid;
  logic signed [DW-1:0]          best, best_a, best_rhs, cur_a, cur_rhs, fct, pj, wij;
  logic signed [sts_pkg::ACC_W-1:0]  acc;
  logic signed [sts_pkg::PROD_W-1:0] prod, lhs;
  sts_pkg::status_t              status;
  sts_pkg::out_word_t            out_word;
  logic                          out_valid;

  logic                                in_fire;
  logic                                out_fire;
  logic                                w_we;
  logic [sts_pkg::WADDR_W-1:0]         w_waddr, w_raddr;
  logic signed [DW-1:0]                w_wdata;
  logic signed [DW-1:0]                mul_a, mul_b;
  logic [sts_pkg::COL_W-1:0]           cost_idx;
  logic signed [DW-1:0]                cost_work;
  logic                                div_start, div_done;
  logic signed [DW-1:0]                div_q;
  logic signed [DW-1:0]                su_value, ru_value;
  logic signed [sts_pkg::PROD_W-1:0]   qprod;

  assign item.ready   = (state == IDLE);
  assign in_fire      = item.valid && item.ready;
  assign result.valid = out_valid;
  assign result.data  = out_word;
  assign out_fire     = out_valid && result.ready;
  assign qprod        = prod >>> sts_pkg::FRAC_BITS;

  // Working cost of a column: unused columns cost zero, minimization negates.
  always_comb begin
    cost_idx = (state == BASIS) ? e : j[sts_pkg::COL_W-1:0];
    if (sts_pkg::NCOL_W'(cost_idx) >= nv) cost_work = '0;
    else if (minimize) cost_work = sts_pkg::neg32(cost_row[cost_idx]);
    else cost_work = cost_row[cost_idx];
  end

  // Standardized set-up value of entry (i, j).
  always_comb begin
    logic neg, ge;
    neg = rhs_row[i][DW-1];
    ge  = row_ge[i] ^ neg;
    if (j == sts_pkg::JCOL_W'(sts_pkg::MAX_COLS))
      su_value = neg ? sts_pkg::neg32(rhs_row[i]) : rhs_row[i];
    else if (sts_pkg::NCOL_W'(j) < nv)
      su_value = neg ? sts_pkg::neg32(coef_rdata) : coef_rdata;
    else if (sts_pkg::NCOL_W'(j) == nv + sts_pkg::NCOL_W'(i))
      su_value = ge ? -sts_pkg::Q_ONE : sts_pkg::Q_ONE;
    else su_value = '0;
  end

  // Elimination of the entering column from a non-pivot row.
  always_comb begin
    if (j == sts_pkg::JCOL_W'(e)) ru_value = '0;
    else ru_value = sts_pkg::sat64(sts_pkg::PROD_W'(wij) - qprod);
  end

  // Tableau memory port control and shared multiplier operands.
  always_comb begin
    w_raddr   = sts_pkg::widx(i, j);
    w_we      = 1'b0;
    w_waddr   = sts_pkg::widx(i, j);
    w_wdata   = su_value;
    mul_a     = basis_cost[i];
    mul_b     = w_rdata;
    div_start = 1'b0;
    case (state)
      SU_WR:   w_we = 1'b1;
      RT_RDA:  w_raddr = sts_pkg::widx(i, sts_pkg::JCOL_W'(e));
      RT_RDB:  w_raddr = sts_pkg::widx(i, sts_pkg::JCOL_W'(sts_pkg::MAX_COLS));
      RT_M1: begin
        mul_a = cur_rhs;
        mul_b = best_a;
      end
      RT_M2: begin
        mul_a = best_rhs;
        mul_b = cur_a;
      end
      PD_RD:   w_raddr = sts_pkg::widx(p, j);
      PD_GO:   div_start = 1'b1;
      PD_WAIT: begin
        w_we    = div_done;
        w_waddr = sts_pkg::widx(p, j);
        w_wdata = div_q;
      end
      RU_ROW:  w_raddr = sts_pkg::widx(i, sts_pkg::JCOL_W'(e));
      RU_RDP:  w_raddr = sts_pkg::widx(p, j);
      RU_MUL: begin
        mul_a = pj;
        mul_b = fct;
      end
      RU_WR: begin
        w_we    = 1'b1;
        w_wdata = ru_value;
      end
      OB_RD, RP_RD: w_raddr = sts_pkg::widx(i, sts_pkg::JCOL_W'(sts_pkg::MAX_COLS));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (w_we) w_mem[w_waddr] <= w_wdata;
    w_rdata <= w_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_fire && item.data.kind == sts_pkg::KIND_COEF)
      coef_mem[{item.data.row, item.data.col}] <= item.data.value;
    coef_rdata <= coef_mem[{i, j[sts_pkg::COL_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  sts_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (w_rdata),
    .divisor  (best_a),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      out_valid   <= 1'b0;
      pivot_count <= '0;
      status      <= sts_pkg::STATUS_OPTIMAL;
      i           <= '0;
      j           <= '0;
      for (int k = 0; k < sts_pkg::MAX_ROWS; k++) begin
        basis_cost[k]   <= '0;
        basis_column[k] <= sts_pkg::COL_W'(k + 1);
        row_ge[k]       <= 1'b0;
      end
      for (int k = 0; k < sts_pkg::MAX_COLS; k++) reduced_cost[k] <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (in_fire) begin
            case (item.data.kind)
              sts_pkg::KIND_COST: cost_row[item.data.col] <= item.data.value;
              sts_pkg::KIND_RHS: begin
                rhs_row[item.data.row] <= item.data.value;
                row_ge[item.data.row]  <= item.data.relation_ge;
              end
              sts_pkg::KIND_SOLVE: begin
                i           <= '0;
                j           <= '0;
                pivot_count <= '0;
                status      <= sts_pkg::STATUS_OPTIMAL;
                state       <= SU_RD;
              end
              default: ;
            endcase
          end
        end

        // Set-up: copy and standardize the loaded rows.
        SU_RD: state <= SU_WR;
        SU_WR: begin
          if (j == sts_pkg::JCOL_W'(sts_pkg::MAX_COLS)) begin
            basis_column[i] <= sts_pkg::COL_W'(nv + sts_pkg::NCOL_W'(i));
            basis_cost[i]   <= '0;
            j <= '0;
            if (i == nr_m1) state <= RC_CHK;
            else begin
              i     <= i + 1'b1;
              state <= SU_RD;
            end
          end else begin
            j     <= j + 1'b1;
            state <= SU_RD;
          end
        end

        // Reduced costs c_j - z_j, one column at a time.
        RC_CHK: begin
          i   <= '0;
          acc <= '0;
          if (sts_pkg::NCOL_W'(j) >= ncols) begin
            reduced_cost[j[sts_pkg::COL_W-1:0]] <= '0;
            if (j == sts_pkg::JCOL_W'(sts_pkg::MAX_COLS - 1)) begin
              j       <= '0;
              best    <= '0;
              e_valid <= 1'b0;
              state   <= EN_SCAN;
            end else j <= j + 1'b1;
          end else state <= RC_RD;
        end
        RC_RD:  state <= RC_MUL;
        RC_MUL: state <= RC_ACC;
        RC_ACC: begin
          acc <= acc + sts_pkg::ACC_W'(qprod);
          if (i == nr_m1) state <= RC_FIN;
          else begin
            i     <= i + 1'b1;
            state <= RC_RD;
          end
        end
        RC_FIN: begin
          reduced_cost[j[sts_pkg::COL_W-1:0]] <=
            sts_pkg::sat64(sts_pkg::PROD_W'(cost_work) - sts_pkg::PROD_W'(acc));
          if (j == sts_pkg::JCOL_W'(sts_pkg::MAX_COLS - 1)) begin
            j       <= '0;
            best    <= '0;
            e_valid <= 1'b0;
            state   <= EN_SCAN;
          end else begin
            j     <= j + 1'b1;
            state <= RC_CHK;
          end
        end

        // Entering column: largest positive reduced cost, first on ties.
        EN_SCAN: begin
          if (reduced_cost[j[sts_pkg::COL_W-1:0]] > best) begin
            best    <= reduced_cost[j[sts_pkg::COL_W-1:0]];
            e       <= j[sts_pkg::COL_W-1:0];
            e_valid <= 1'b1;
          end
          if (sts_pkg::NCOL_W'(j) == ncols_m1) state <= EN_DEC;
          else j <= j + 1'b1;
        end
        EN_DEC: begin
          i       <= '0;
          p_valid <= 1'b0;
          if (!e_valid) state <= OB_RD;
          else if (pivot_count >= iteration_limit) begin
            status <= sts_pkg::STATUS_LIMIT;
            state  <= OB_RD;
          end else state <= RT_RDA;
          acc <= '0;
        end

        // Ratio test by cross-multiplication.
        RT_RDA: state <= RT_RDB;
        RT_RDB: begin
          cur_a <= w_rdata;
          state <= RT_CHK;
        end
        RT_CHK: begin
          cur_rhs <= w_rdata;
          if (cur_a <= 0 || !p_valid) begin
            if (cur_a > 0) begin
              p        <= i;
              p_valid  <= 1'b1;
              best_a   <= cur_a;
              best_rhs <= w_rdata;
            end
            if (i == nr_m1) state <= RT_END;
            else begin
              i     <= i + 1'b1;
              state <= RT_RDA;
            end
          end else state <= RT_M1;
        end
        RT_M1: state <= RT_M2;
        RT_M2: begin
          lhs   <= prod;
          state <= RT_CMP;
        end
        RT_CMP: begin
          if (lhs < prod) begin
            p        <= i;
            best_a   <= cur_a;
            best_rhs <= cur_rhs;
          end
          if (i == nr_m1) state <= RT_END;
          else begin
            i     <= i + 1'b1;
            state <= RT_RDA;
          end
        end
        RT_END: begin
          j <= '0;
          i <= '0;
          if (!p_valid) begin
            status <= sts_pkg::STATUS_UNBOUNDED;
            acc    <= '0;
            state  <= OB_RD;
          end else state <= PD_RD;
        end

        // Divide the pivot row by the pivot.
        PD_RD: state <= PD_GO;
        PD_GO: state <= PD_WAIT;
        PD_WAIT: begin
          if (div_done) begin
            if (j == sts_pkg::JCOL_W'(sts_pkg::MAX_COLS)) begin
              j     <= '0;
              state <= RU_ROW;
            end else begin
              j     <= j + 1'b1;
              state <= PD_RD;
            end
          end
        end

        // Eliminate the entering column from every other row.
        RU_ROW: begin
          if (i == p) begin
            if (i == nr_m1) state <= BASIS;
            else i <= i + 1'b1;
          end else state <= RU_F;
        end
        RU_F: begin
          fct   <= w_rdata;
          j     <= '0;
          state <= RU_RDP;
        end
        RU_RDP: state <= RU_RDI;
        RU_RDI: begin
          pj    <= w_rdata;
          state <= RU_MUL;
        end
        RU_MUL: begin
          wij   <= w_rdata;
          state <= RU_WR;
        end
        RU_WR: begin
          if (j == sts_pkg::JCOL_W'(sts_pkg::MAX_COLS)) begin
            j <= '0;
            if (i == nr_m1) state <= BASIS;
            else begin
              i     <= i + 1'b1;
              state <= RU_ROW;
            end
          end else begin
            j     <= j + 1'b1;
            state <= RU_RDP;
          end
        end
        BASIS: begin
          basis_column[p] <= e;
          basis_cost[p]   <= cost_work;
          pivot_count     <= pivot_count + 1'b1;
          j               <= '0;
          state           <= RC_CHK;
        end

        // Objective: sum of basis cost times right-hand side.
        OB_RD:  state <= OB_MUL;
        OB_MUL: state <= OB_ACC;
        OB_ACC: begin
          if (i == nr_m1) begin
            out_word.result_kind  <= sts_pkg::RK_OBJECTIVE;
            out_word.var_index    <= '0;
            out_word.result_value <= sts_pkg::sat64(minimize ?
              -sts_pkg::PROD_W'(acc + sts_pkg::ACC_W'(qprod)) :
               sts_pkg::PROD_W'(acc + sts_pkg::ACC_W'(qprod)));
            out_word.status       <= status;
            out_word.last         <= 1'b0;
            out_valid             <= 1'b1;
            i                     <= '0;
            state                 <= OUT_WAIT;
          end else begin
            acc   <= acc + sts_pkg::ACC_W'(qprod);
            i     <= i + 1'b1;
            state <= OB_RD;
          end
        end

        // Report: one word per row, then back to idle after the last one.
        RP_RD: state <= OUT_WAIT;
        OUT_WAIT: begin
          if (!out_valid) begin
            out_word.result_kind  <= sts_pkg::RK_BASIC;
            out_word.var_index    <= basis_column[i];
            out_word.result_value <= w_rdata;
            out_word.status       <= status;
            out_word.last         <= (i == nr_m1);
            out_valid             <= 1'b1;
            i                     <= i + 1'b1;
          end else if (out_fire) begin
            out_valid <= 1'b0;
            if (out_word.last) state <= IDLE;
            else state <= RP_RD;
          end
        end

        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/sts_divider.sv */
// ----------------------------------------------------------------------------
// sts_divider: radix-2 restoring divider for the pivot row
// Computes sat32((a << FRAC_BITS) / d) for d > 0, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_divider (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [sts_pkg::DATA_W-1:0] dividend,
  input  wire logic signed [sts_pkg::DATA_W-1:0] divisor,
  output logic                                   done,
  output logic signed [sts_pkg::DATA_W-1:0]      quotient
);

  localparam int NUM_W = sts_pkg::DATA_W + sts_pkg::FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic                       busy;
  logic [CNT_W-1:0]           count;
  logic [sts_pkg::DATA_W-1:0] rem;
  logic [NUM_W-1:0]           quo;
  logic [sts_pkg::DATA_W-1:0] dvs;
  logic                       negative;
  logic [sts_pkg::DATA_W:0]   trial;
  logic                       fits;
  logic [NUM_W-1:0]           quo_next;
  logic [sts_pkg::DATA_W-1:0] mag_a;

  assign mag_a    = dividend[sts_pkg::DATA_W-1] ? -dividend : dividend;
  assign trial    = {rem, quo[NUM_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quo_next = {quo[NUM_W-2:0], fits};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      count    <= CNT_W'(NUM_W);
      rem      <= '0;
      quo      <= {mag_a, {sts_pkg::FRAC_BITS{1'b0}}};
      dvs      <= divisor;
      negative <= dividend[sts_pkg::DATA_W-1];
    end else if (busy) begin
      rem   <= fits ? sts_pkg::DATA_W'(trial - {1'b0, dvs}) : trial[sts_pkg::DATA_W-1:0];
      quo   <= quo_next;
      count <= count - 1'b1;
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
        if (negative) begin
          quotient <= sts_pkg::sat64(-$signed({{sts_pkg::PROD_W-NUM_W{1'b0}}, quo_next}));
        end else begin
          quotient <= sts_pkg::sat64($signed({{sts_pkg::PROD_W-NUM_W{1'b0}}, quo_next}));
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the fixed-point simplex tableau solver
// Loads small linear programs, solves them under many register settings and
// compares every result word with a built-in tableau simplex predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import sts_pkg::*;

  // Generous bound on the whole run, in clock cycles.
  localparam int CYCLE_LIMIT = 20_000_000;
  // Quiet cycles after the last result before a register write or the end.
  localparam int DRAIN_CYCLES = 60;
  // Load words wanted in the random part.
  localparam int LOAD_GOAL = 220;

  logic clk;
  logic rst;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sts_in_if item ();
  sts_out_if result ();

  simplex_tableau_solver_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item(item.sink),
    .result(result.source)
  );

  // One row of the directed table. Where known is set, the objective word
  // of a solve is typed in and replaces the predicted one.
  typedef struct {
    in_word_t w;
    bit known;
    logic signed [31:0] obj;
    status_t st;
  } dir_row_t;

  // Copy of the loaded program, as the block should hold it.
  int cost_mem [MAX_COLS];
  int tab_mem [MAX_ROWS][STRIDE];
  bit ge_mem [MAX_ROWS];
  bit cost_loaded [MAX_COLS];
  bit tab_loaded [MAX_ROWS][STRIDE];

  // Register copies.
  int reg_rows, reg_vars, reg_iter;
  bit reg_min;

  out_word_t solution_q[$];
  dir_row_t dir_rows[$];
  int mismatches;
  int words_sent;
  int cycles;
  bit park_results;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none, sometimes short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int sat32(longint v);
    if (v > longint'(INT_MAX)) return INT_MAX;
    if (v < longint'(INT_MIN)) return INT_MIN;
    return int'(v);
  endfunction

  // Q16.16 product, rounded toward minus infinity.
  function automatic longint qprod(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    if (p >= 0) return p >>> FRAC_BITS;
    return -(((-p) + ((64'sd1 << FRAC_BITS) - 1)) >>> FRAC_BITS);
  endfunction

  // Q16.16 quotient, truncated toward zero.
  function automatic int qquot(int a, int d);
    return sat32((longint'(a) * (64'sd1 <<< FRAC_BITS)) / longint'(d));
  endfunction

  function automatic int rows_in_use();
    int r;
    r = reg_rows;
    if (r < 1) r = 1;
    if (r > MAX_ROWS) r = MAX_ROWS;
    return r;
  endfunction

  function automatic int vars_in_use(int nr);
    int v;
    v = reg_vars;
    if (v < 1) v = 1;
    if (v > MAX_COLS - nr) v = MAX_COLS - nr;
    return v;
  endfunction

  // Solve a copy of the loaded program and queue the words it reports:
  // the objective first, then the basic variable of every row.
  function automatic void predict_solution();
    int w [MAX_ROWS][STRIDE];
    int c [MAX_COLS];
    int rc [MAX_COLS];
    int bcost [MAX_ROWS];
    int bcol [MAX_ROWS];
    int nr, nv, ncols, pivots, best, e, p, piv, f, v, rhs;
    bit ge, neg;
    status_t st;
    longint z, obj;
    out_word_t o;
    nr = rows_in_use();
    nv = vars_in_use(nr);
    ncols = nr + nv;
    st = STATUS_OPTIMAL;
    pivots = 0;
    obj = 0;
    for (int j = 0; j < MAX_COLS; j++) begin
      v = (j < nv) ? cost_mem[j] : 0;
      c[j] = reg_min ? sat32(-longint'(v)) : v;
    end
    for (int i = 0; i < MAX_ROWS; i++)
      for (int j = 0; j < STRIDE; j++) w[i][j] = 0;
    // Rows with a negative right-hand side are negated and flip relation.
    for (int i = 0; i < nr; i++) begin
      rhs = tab_mem[i][MAX_COLS];
      neg = rhs < 0;
      ge = ge_mem[i] ^ neg;
      for (int j = 0; j < nv; j++)
        w[i][j] = neg ? sat32(-longint'(tab_mem[i][j])) : tab_mem[i][j];
      w[i][MAX_COLS] = neg ? sat32(-longint'(rhs)) : rhs;
      w[i][nv + i] = ge ? -int'(Q_ONE) : int'(Q_ONE);
      bcol[i] = nv + i;
      bcost[i] = 0;
    end
    forever begin
      for (int j = 0; j < MAX_COLS; j++) begin
        z = 0;
        for (int i = 0; i < nr; i++) z += qprod(bcost[i], w[i][j]);
        rc[j] = (j < ncols) ? sat32(longint'(c[j]) - z) : 0;
      end
      best = 0;
      e = -1;
      for (int j = 0; j < ncols; j++)
        if (rc[j] > best) begin
          best = rc[j];
          e = j;
        end
      if (e < 0) break;
      if (pivots >= reg_iter) begin
        st = STATUS_LIMIT;
        break;
      end
      // Minimum ratio test by cross-multiplication, first row on ties.
      p = -1;
      for (int i = 0; i < nr; i++) begin
        if (w[i][e] > 0) begin
          if (p < 0 || longint'(w[i][MAX_COLS]) * longint'(w[p][e]) <
                       longint'(w[p][MAX_COLS]) * longint'(w[i][e]))
            p = i;
        end
      end
      if (p < 0) begin
        st = STATUS_UNBOUNDED;
        break;
      end
      piv = w[p][e];
      for (int j = 0; j < STRIDE; j++) w[p][j] = qquot(w[p][j], piv);
      for (int i = 0; i < nr; i++) begin
        if (i != p) begin
          f = w[i][e];
          for (int j = 0; j < STRIDE; j++)
            w[i][j] = sat32(longint'(w[i][j]) - qprod(w[p][j], f));
          w[i][e] = 0;
        end
      end
      bcol[p] = e;
      bcost[p] = c[e];
      pivots++;
    end
    for (int i = 0; i < nr; i++) obj += qprod(bcost[i], w[i][MAX_COLS]);
    if (reg_min) obj = -obj;
    o.result_kind = RK_OBJECTIVE;
    o.var_index = '0;
    o.result_value = sat32(obj);
    o.status = st;
    o.last = 1'b0;
    solution_q.push_back(o);
    for (int i = 0; i < nr; i++) begin
      o.result_kind = RK_BASIC;
      o.var_index = 4'(bcol[i]);
      o.result_value = w[i][MAX_COLS];
      o.last = (i == nr - 1);
      solution_q.push_back(o);
    end
  endfunction

  // Track an accepted word in the program copy or solve it.
  function automatic void absorb_word(in_word_t w);
    case (w.kind)
      KIND_COST: begin
        cost_mem[w.col] = w.value;
        cost_loaded[w.col] = 1'b1;
      end
      KIND_COEF: begin
        tab_mem[w.row][w.col] = w.value;
        tab_loaded[w.row][w.col] = 1'b1;
      end
      KIND_RHS: begin
        tab_mem[w.row][MAX_COLS] = w.value;
        tab_loaded[w.row][MAX_COLS] = 1'b1;
        ge_mem[w.row] = w.relation_ge;
      end
      default: predict_solution();
    endcase
  endfunction

  // Offer one word after a random gap and wait until the block takes it.
  task automatic send_word(in_word_t w);
    int n;
    n = gap_len();
    if (n > 0) begin
      item.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    item.valid <= 1'b1;
    item.data <= w;
    do @(posedge clk); while (!item.ready);
    absorb_word(w);
    if (w.kind != KIND_SOLVE) words_sent++;
    @(negedge clk);
  endtask

  function automatic in_word_t make_word(kind_t k, int r, int c, int v, bit ge);
    in_word_t w;
    w.kind = k;
    w.row = 3'(r);
    w.col = 4'(c);
    w.value = v;
    w.relation_ge = ge;
    return w;
  endfunction

  // Small well-formed Q16.16 value, mostly non-negative.
  function automatic int tame_value(bit allow_neg);
    int v;
    v = ($urandom_range(0, 8) << FRAC_BITS) | ($urandom_range(0, 3) << 14);
    if (allow_neg && $urandom_range(0, 4) == 0) v = -v;
    return v;
  endfunction

  // Stop offering words, wait for every expected word, then let the block
  // settle so that a register write finds it idle.
  task automatic wait_drained();
    item.valid <= 1'b0;
    while (solution_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(int nc, int nv, bit mn, int lim);
    cfg_we <= 1'b1;
    cfg_index <= CFG_NUM_CONSTRAINTS;
    cfg_data <= 8'(nc & 15);
    @(negedge clk);
    cfg_index <= CFG_NUM_VARIABLES;
    cfg_data <= 8'(nv & 15);
    @(negedge clk);
    cfg_index <= CFG_MINIMIZE;
    cfg_data <= 8'(mn);
    @(negedge clk);
    cfg_index <= CFG_ITERATION_LIMIT;
    cfg_data <= 8'(lim);
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_rows = nc & 15;
    reg_vars = nv & 15;
    reg_min = mn;
    reg_iter = lim & 255;
  endtask

  // Before a solve, load every entry it will read that was never written,
  // so that no read of an unwritten entry is ever caused.
  task automatic fill_unloaded(bit tame);
    int nr, nv;
    nr = rows_in_use();
    nv = vars_in_use(nr);
    for (int j = 0; j < nv; j++)
      if (!cost_loaded[j])
        send_word(make_word(KIND_COST, 0, j, tame ? tame_value(0) : $urandom(), 1'b0));
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nv; j++)
        if (!tab_loaded[i][j])
          send_word(make_word(KIND_COEF, i, j, tame ? tame_value(1) : $urandom(), 1'b0));
      if (!tab_loaded[i][MAX_COLS])
        send_word(make_word(KIND_RHS, i, 0, tame ? tame_value(0) : $urandom(),
                            $urandom_range(0, 1)));
    end
  endtask

  // One random phase: a register setting, then a few programs solved.
  // Most loads are small well-formed entries inside the used area; the rest
  // are raw 32-bit noise anywhere in the arrays.
  task automatic random_phase(int nc, int nv, bit mn, int lim, int solves, bit press);
    int nr, nu, k;
    bit tame;
    in_word_t w;
    wait_drained();
    write_regs(nc, nv, mn, lim);
    nr = rows_in_use();
    nu = vars_in_use(nr);
    tame = (lim > 40) || ($urandom_range(0, 5) != 0);
    for (int s = 0; s < solves; s++) begin
      k = $urandom_range(2, 3 * (nr + nu));
      for (int n = 0; n < k; n++) begin
        if ($urandom_range(0, 6) == 0 && !tame) begin
          w = make_word(kind_t'($urandom_range(0, 2)), $urandom_range(0, 7),
                        $urandom_range(0, 15), $urandom(), $urandom_range(0, 1));
        end else begin
          case ($urandom_range(0, 2))
            0: w = make_word(KIND_COST, $urandom_range(0, 7), $urandom_range(0, nu - 1),
                             tame_value(1), $urandom_range(0, 1));
            1: w = make_word(KIND_COEF, $urandom_range(0, nr - 1),
                             $urandom_range(0, nu - 1), tame_value(1), $urandom_range(0, 1));
            default: w = make_word(KIND_RHS, $urandom_range(0, nr - 1),
                                   $urandom_range(0, 15), tame_value(1),
                                   $urandom_range(0, 3) == 0);
          endcase
        end
        send_word(w);
      end
      fill_unloaded(tame);
      // Park the result channel so the solve's result words are held back and the block
      // has to refuse the load words offered behind them.
      if (press && s == 0) park_results = 1'b1;
      send_word(make_word(KIND_SOLVE, $urandom_range(0, 7), $urandom_range(0, 15),
                          $urandom(), $urandom_range(0, 1)));
    end
  endtask

  // Result side: random stalls, plus a long hold-off each time the result
  // channel is parked, once results are waiting, counted here in cycles.
  initial begin
    result.ready = 1'b0;
    forever begin
      int n;
      if (park_results) begin
        park_results = 1'b0;
        result.ready <= 1'b0;
        @(negedge clk);
        while (!result.valid) @(negedge clk);
        repeat (2000) @(negedge clk);
      end
      n = gap_len();
      if (n > 0) begin
        result.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      result.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Every accepted result word is held against the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    out_word_t got;
    if (!rst && result.valid && result.ready) begin
      got = result.data;
      if (solution_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: kind %0d var %0d value %h status %0d last %0d",
                   got.result_kind, got.var_index, got.result_value, got.status,
                   got.last);
      end else begin
        want = solution_q.pop_front();
        if (got.result_kind !== want.result_kind || got.var_index !== want.var_index ||
            got.result_value !== want.result_value || got.status !== want.status ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected kind %0d var %0d value %h status %0d ",
                      "last %0d, got kind %0d var %0d value %h status %0d last %0d"},
                     want.result_kind, want.var_index, want.result_value, want.status,
                     want.last, got.result_kind, got.var_index, got.result_value,
                     got.status, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_row(kind_t k, int r, int c, int v, bit ge, bit known = 0,
                         int obj = 0, status_t st = STATUS_OPTIMAL);
    dir_row_t d;
    d.w = make_word(k, r, c, v, ge);
    d.known = known;
    d.obj = obj;
    d.st = st;
    dir_rows.push_back(d);
  endtask

  initial begin
    int at;
    mismatches = 0;
    words_sent = 0;
    cycles = 0;
    park_results = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_NUM_CONSTRAINTS;
    cfg_data = '0;
    item.valid = 1'b0;
    item.data = '0;
    for (int i = 0; i < MAX_ROWS; i++) begin
      ge_mem[i] = 1'b0;
      for (int j = 0; j < STRIDE; j++) begin
        tab_mem[i][j] = 0;
        tab_loaded[i][j] = 1'b0;
      end
    end
    for (int j = 0; j < MAX_COLS; j++) begin
      cost_mem[j] = 0;
      cost_loaded[j] = 1'b0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, one row and one variable.
    // max 3x with x <= 4 gives 12.
    add_row(KIND_COST, 0, 0, 32'sh0003_0000, 1'b0);
    add_row(KIND_COEF, 0, 0, 32'sh0001_0000, 1'b0);
    add_row(KIND_RHS, 0, 0, 32'sh0004_0000, 1'b0);
    add_row(KIND_SOLVE, 0, 0, 0, 1'b0, 1, 32'sh000C_0000, STATUS_OPTIMAL);
    // A negative coefficient leaves no pivot row: unbounded at objective 0.
    add_row(KIND_COEF, 0, 0, -32'sh0001_0000, 1'b0);
    add_row(KIND_SOLVE, 0, 0, 0, 1'b0, 1, 0, STATUS_UNBOUNDED);
    // A negative right-hand side negates the row and turns it into x >= 4:
    // x enters at 12, then the surplus column has no pivot row.
    add_row(KIND_RHS, 0, 0, -32'sh0004_0000, 1'b0);
    add_row(KIND_SOLVE, 0, 0, 0, 1'b0, 1, 32'sh000C_0000, STATUS_UNBOUNDED);
    // The most negative cost never enters: nothing moves.
    add_row(KIND_COST, 0, 0, INT_MIN, 1'b0);
    add_row(KIND_SOLVE, 0, 0, 0, 1'b0, 1, 0, STATUS_OPTIMAL);
    // Extremes: saturated objective, most negative rhs, >= with zero rhs.
    add_row(KIND_COST, 0, 0, INT_MAX, 1'b1);
    add_row(KIND_COEF, 0, 0, 32'sh0000_0001, 1'b1);
    add_row(KIND_RHS, 0, 15, INT_MAX, 1'b0);
    add_row(KIND_SOLVE, 7, 15, -1, 1'b1);
    add_row(KIND_RHS, 0, 0, INT_MIN, 1'b1);
    add_row(KIND_SOLVE, 0, 0, 0, 1'b0);
    add_row(KIND_RHS, 0, 0, 0, 1'b1);
    add_row(KIND_COEF, 0, 0, -1, 1'b0);
    add_row(KIND_SOLVE, 0, 0, 0, 1'b0);
    // Far corners of the arrays, unused by a one-row solve.
    add_row(KIND_COEF, 7, 15, -1, 1'b0);
    add_row(KIND_COST, 5, 15, INT_MIN, 1'b0);
    add_row(KIND_RHS, 7, 9, INT_MAX, 1'b1);
    add_row(KIND_SOLVE, 0, 0, 0, 1'b0);

    write_regs(1, 1, 1'b0, 64);
    foreach (dir_rows[n]) begin
      at = solution_q.size();
      send_word(dir_rows[n].w);
      if (dir_rows[n].known) begin
        solution_q[at].result_value = dir_rows[n].obj;
        solution_q[at].status = dir_rows[n].st;
      end
    end

    // Register extremes first, one with the result channel parked, then
    // random settings until enough load words have gone in.
    random_phase(8, 8, 1'b0, 255, 2, 1'b1);
    random_phase(15, 15, 1'b1, 3, 2, 1'b0);
    random_phase(0, 0, 1'b0, 0, 2, 1'b0);
    random_phase(2, 3, 1'b0, 0, 1, 1'b0);
    random_phase(8, 1, 1'b1, 1, 2, 1'b0);
    random_phase(1, 8, 1'b0, 255, 2, 1'b0);
    while (words_sent < LOAD_GOAL)
      random_phase($urandom_range(0, 4), $urandom_range(0, 5), $urandom_range(0, 1),
                   $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 12),
                   $urandom_range(1, 3), $urandom_range(0, 7) == 0);

    wait_drained();
    if (mismatches == 0 && solution_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
